### hdl/lcmm_pkg.sv
// lcmm_pkg: shared types and constants of the lc sample min/max tracker
`default_nettype none

package lcmm_pkg;

   // default widths of the running marks
   localparam int FREQ_BITS_DEF = 24;
   localparam int PEAK_BITS_DEF = 10;

   // percent result: 7 quotient bits cover 0..100
   localparam int PCT_BITS  = 7;
   localparam int PCT_SCALE = 100;
   localparam int CNT_BITS  = $clog2(PCT_BITS);

   // visualiser frame
   localparam int                   FRAME_LEN      = 6;
   localparam int                   FRAME_IDX_BITS = $clog2(FRAME_LEN);
   localparam logic [FRAME_IDX_BITS-1:0] FRAME_LAST = FRAME_IDX_BITS'(FRAME_LEN - 1);
   localparam logic [7:0]           FRAME_HEAD     = 8'h03;
   localparam logic [7:0]           FRAME_TAIL     = 8'hFC;

   // result kinds
   localparam logic KIND_STATS = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   // one measurement item
   typedef struct packed {
      logic [23:0] frequency;
      logic [9:0]  peak_sample;
      logic [15:0] cycle_count;
      logic        button_level;
   } lcmm_req_type;

   // one result item
   typedef struct packed {
      logic        kind;
      logic [9:0]  peak_value;
      logic [9:0]  peak_spread;
      logic [6:0]  peak_percent;
      logic [15:0] cycle_value;
      logic [23:0] freq_value;
      logic [23:0] freq_spread;
      logic [6:0]  freq_percent;
      logic [7:0]  frame_byte;
      logic        last;
   } lcmm_rsp_type;

   // status from the shared percent divider
   typedef struct packed {
      logic                done;
      logic [PCT_BITS-1:0] quot;
   } lcmm_div_stat_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPREAD,
      ST_FREQ_DIV,
      ST_PEAK_DIV,
      ST_STATS,
      ST_FRAME
   } lcmm_state_type;

endpackage

`default_nettype wire

### hdl/lcmm_pct_div.sv
// lcmm_pct_div: iterative restoring divider giving 100 * num / den, one quotient bit a cycle
`default_nettype none

module lcmm_pct_div #(
   parameter int DW = lcmm_pkg::FREQ_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [DW-1:0]              num,
   input  wire logic [DW-1:0]              den,
   output      lcmm_pkg::lcmm_div_stat_type stat
);
   import lcmm_pkg::*;

   localparam int RW = DW + PCT_BITS;

   logic [RW-1:0]       rem_ff, rem_in;
   logic [RW-1:0]       dsh_ff, dsh_in;
   logic [PCT_BITS-1:0] q_ff, q_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [RW-1:0]       num_w;
   logic [RW:0]         diff;

   assign num_w = RW'(num);
   assign diff  = {1'b0, rem_ff} - {1'b0, dsh_ff};

   // load scaled numerator, then one trial subtract per cycle
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (!diff[RW]) begin
            rem_in = diff[RW-1:0];
            q_in   = {q_ff[PCT_BITS-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[PCT_BITS-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(PCT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         // times 100 as 64 + 32 + 4
         rem_in  = (num_w << 6) + (num_w << 5) + (num_w << 2);
         dsh_in  = RW'(den) << (PCT_BITS - 1);
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign stat.done = done_ff;
   assign stat.quot = q_ff;

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");
   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(start))
      else $error("divider went busy without a start");
`endif

endmodule

`default_nettype wire

### hdl/lc_sample_min_max_tracker_top.sv
// lc_sample_min_max_tracker_top: running min/max tracker with statistics and frame reports
//
// req channel: one lc tank measurement per item (frequency, peak sample, cycle count,
// button level). req_stall is high from acceptance until the item's work is done.
// rsp channel: statistics results (kind 0) or six frame byte results (kind 1),
// held in an output register until the receiver drops rsp_stall.
// A falling edge of the button toggles the report mode; while the button reads low the
// marks are cleared and the item yields no result, and the tracker stays ready for the next item.
// Statistics: the two percent values run one after the other through a shared divider
// that yields one quotient bit a cycle; the result is loaded once both percents are done,
// and the next item is taken after the result load.
// Frame: one byte loaded per cycle while the output is free; the first byte is loaded in the
// frame state that follows acceptance, and the next item is taken after the last byte load.
// A stalled receiver holds the current result and pauses the sequencer before the next
// result load; a new item can be accepted while the last result still waits.
// Reset (synchronous): marks to their empty values, button released, statistics mode,
// no result pending.
`default_nettype none

module lc_sample_min_max_tracker_top #(
   parameter int FREQ_BITS = lcmm_pkg::FREQ_BITS_DEF,
   parameter int PEAK_BITS = lcmm_pkg::PEAK_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire lcmm_pkg::lcmm_req_type req_item,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      lcmm_pkg::lcmm_rsp_type rsp_item
);
   import lcmm_pkg::*;

   localparam int DW = (FREQ_BITS > PEAK_BITS) ? FREQ_BITS : PEAK_BITS;

   lcmm_state_type          state_ff, state_in;
   logic [FREQ_BITS-1:0]    flow_ff, flow_in, fhigh_ff, fhigh_in;
   logic [PEAK_BITS-1:0]    plow_ff, plow_in, phigh_ff, phigh_in;
   logic                    btn_prev_ff, btn_prev_in;
   logic                    mode_ff, mode_in;
   logic [FREQ_BITS-1:0]    freq_ff, freq_in;
   logic [PEAK_BITS-1:0]    peak_ff, peak_in;
   logic [15:0]             cyc_ff, cyc_in;
   logic [FREQ_BITS-1:0]    fspr_ff, fspr_in;
   logic [PEAK_BITS-1:0]    pspr_ff, pspr_in;
   logic [PCT_BITS-1:0]     fpct_ff, fpct_in, ppct_ff, ppct_in;
   logic [FRAME_IDX_BITS-1:0] byte_idx_ff, byte_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lcmm_rsp_type            rsp_item_ff, rsp_item_in;

   logic                    req_acc;
   logic                    out_free;
   logic                    press;
   logic                    div_start;
   logic [DW-1:0]           div_num, div_den;
   lcmm_div_stat_type       div_stat;
   logic [FREQ_BITS-1:0]    freq_w;
   logic [PEAK_BITS-1:0]    peak_w;
   logic [15:0]             peak16;
   logic [7:0]              frame_byte;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign freq_w    = FREQ_BITS'(req_item.frequency);
   assign peak_w    = PEAK_BITS'(req_item.peak_sample);
   assign press     = btn_prev_ff && !req_item.button_level;
   assign peak16    = 16'(peak_ff);

   // frame byte by position
   always_comb begin
      case (byte_idx_ff)
         3'd0:    frame_byte = FRAME_HEAD;
         3'd1:    frame_byte = peak16[7:0];
         3'd2:    frame_byte = peak16[15:8];
         3'd3:    frame_byte = cyc_ff[7:0];
         3'd4:    frame_byte = cyc_ff[15:8];
         default: frame_byte = FRAME_TAIL;
      endcase
   end

   // shared percent divider
   lcmm_pct_div #(
      .DW (DW)
   ) u_pct_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat)
   );

   // sequencer: next state, marks and result load
   always_comb begin
      state_in     = state_ff;
      flow_in      = flow_ff;
      fhigh_in     = fhigh_ff;
      plow_in      = plow_ff;
      phigh_in     = phigh_ff;
      btn_prev_in  = btn_prev_ff;
      mode_in      = mode_ff;
      freq_in      = freq_ff;
      peak_in      = peak_ff;
      cyc_in       = cyc_ff;
      fspr_in      = fspr_ff;
      pspr_in      = pspr_ff;
      fpct_in      = fpct_ff;
      ppct_in      = ppct_ff;
      byte_idx_in  = byte_idx_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start    = 1'b0;
      div_num      = DW'(fhigh_ff - flow_ff);
      div_den      = DW'(fhigh_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               freq_in     = freq_w;
               peak_in     = peak_w;
               cyc_in      = req_item.cycle_count;
               btn_prev_in = req_item.button_level;
               mode_in     = mode_ff ^ press;
               if (!req_item.button_level) begin
                  // button held: back to empty marks, no result
                  flow_in  = '1;
                  fhigh_in = '0;
                  plow_in  = '1;
                  phigh_in = '0;
               end else begin
                  if (freq_w < flow_ff)  flow_in  = freq_w;
                  if (freq_w > fhigh_ff) fhigh_in = freq_w;
                  if (peak_w < plow_ff)  plow_in  = peak_w;
                  if (peak_w > phigh_ff) phigh_in = peak_w;
                  byte_idx_in = '0;
                  state_in    = (mode_ff ^ press) ? ST_FRAME : ST_SPREAD;
               end
            end
         end

         ST_SPREAD: begin
            // spreads and the frequency percent start
            fspr_in   = fhigh_ff - flow_ff;
            pspr_in   = phigh_ff - plow_ff;
            div_start = 1'b1;
            state_in  = ST_FREQ_DIV;
         end

         ST_FREQ_DIV: begin
            div_num = DW'(pspr_ff);
            div_den = DW'(phigh_ff);
            if (div_stat.done) begin
               fpct_in   = (fhigh_ff == '0) ? '0 : div_stat.quot;
               div_start = 1'b1;
               state_in  = ST_PEAK_DIV;
            end
         end

         ST_PEAK_DIV: begin
            if (div_stat.done) begin
               ppct_in  = (phigh_ff == '0) ? '0 : div_stat.quot;
               state_in = ST_STATS;
            end
         end

         ST_STATS: begin
            if (out_free) begin
               rsp_item_in.kind         = KIND_STATS;
               rsp_item_in.peak_value   = 10'(peak_ff);
               rsp_item_in.peak_spread  = 10'(pspr_ff);
               rsp_item_in.peak_percent = ppct_ff;
               rsp_item_in.cycle_value  = cyc_ff;
               rsp_item_in.freq_value   = 24'(freq_ff);
               rsp_item_in.freq_spread  = 24'(fspr_ff);
               rsp_item_in.freq_percent = fpct_ff;
               rsp_item_in.frame_byte   = '0;
               rsp_item_in.last         = 1'b1;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end

         ST_FRAME: begin
            if (out_free) begin
               rsp_item_in              = '0;
               rsp_item_in.kind         = KIND_FRAME;
               rsp_item_in.frame_byte   = frame_byte;
               rsp_item_in.last         = (byte_idx_ff == FRAME_LAST);
               rsp_valid_in             = 1'b1;
               byte_idx_in              = byte_idx_ff + 1'b1;
               if (byte_idx_ff == FRAME_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flow_ff      <= '1;
         fhigh_ff     <= '0;
         plow_ff      <= '1;
         phigh_ff     <= '0;
         btn_prev_ff  <= 1'b1;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flow_ff      <= flow_in;
         fhigh_ff     <= fhigh_in;
         plow_ff      <= plow_in;
         phigh_ff     <= phigh_in;
         btn_prev_ff  <= btn_prev_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      freq_ff     <= freq_in;
      peak_ff     <= peak_in;
      cyc_ff      <= cyc_in;
      fspr_ff     <= fspr_in;
      pspr_ff     <= pspr_in;
      fpct_ff     <= fpct_in;
      ppct_ff     <= ppct_in;
      byte_idx_ff <= byte_idx_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_stats_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.kind == KIND_STATS) |-> rsp_item_ff.last)
      else $error("statistics item without last");
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.freq_percent <= PCT_BITS'(PCT_SCALE)
                        && rsp_item_ff.peak_percent <= PCT_BITS'(PCT_SCALE)))
      else $error("percent above 100");
   a_frame_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FRAME) |-> (byte_idx_ff <= FRAME_LAST))
      else $error("frame byte index out of range");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPREAD) |=> (state_ff == ST_FREQ_DIV && !div_stat.done))
      else $error("frequency percent done too early");
`endif

endmodule

`default_nettype wire

### bench/lcmm_checker.sv
// lcmm_checker: watches both channels of the tracker, predicts each result and compares
`timescale 1ns / 1ps

module lcmm_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire lcmm_pkg::lcmm_req_type req_item,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire lcmm_pkg::lcmm_rsp_type rsp_item,
   output int                          mismatches,
   output int                          outstanding,
   output int                          items_taken,
   output int                          stats_checked,
   output int                          bytes_checked
);
   import lcmm_pkg::*;

   localparam logic [23:0] FREQ_EMPTY = '1;
   localparam logic [9:0]  PEAK_EMPTY = '1;
   localparam int          REPORT_MAX = 10;

   // running marks, button history and report mode of the tracker
   logic [23:0]  freq_lo;
   logic [23:0]  freq_hi;
   logic [9:0]   peak_lo;
   logic [9:0]   peak_hi;
   logic         btn_last;
   logic         frame_mode;

   lcmm_rsp_type due_results[$];
   int           mismatch_count;
   int           results_seen;
   int           item_count;
   int           stats_count;
   int           byte_count;

   function automatic logic [6:0] spread_percent(input longint unsigned spread,
                                                 input longint unsigned top);
      if (top == 0)
         return '0;
      return 7'((spread * PCT_SCALE) / top);
   endfunction

   task automatic empty_marks();
      freq_lo = FREQ_EMPTY;
      freq_hi = '0;
      peak_lo = PEAK_EMPTY;
      peak_hi = '0;
   endtask

   // one measurement: button edge first, then marks, then clear or report
   task automatic fold_measurement(input lcmm_req_type m);
      lcmm_rsp_type r;
      logic [23:0]  fspr;
      logic [9:0]   pspr;
      logic [7:0]   frame [FRAME_LEN];
      if (m.button_level != btn_last) begin
         btn_last = m.button_level;
         if (!m.button_level)
            frame_mode = !frame_mode;
      end
      if (m.frequency < freq_lo) freq_lo = m.frequency;
      if (m.frequency > freq_hi) freq_hi = m.frequency;
      if (m.peak_sample > peak_hi) peak_hi = m.peak_sample;
      if (m.peak_sample < peak_lo) peak_lo = m.peak_sample;
      // button held low: marks cleared, nothing emitted
      if (!m.button_level) begin
         empty_marks();
         return;
      end
      if (!frame_mode) begin
         fspr = freq_hi - freq_lo;
         pspr = peak_hi - peak_lo;
         r = '0;
         r.kind         = KIND_STATS;
         r.peak_value   = m.peak_sample;
         r.peak_spread  = pspr;
         r.peak_percent = spread_percent(pspr, peak_hi);
         r.cycle_value  = m.cycle_count;
         r.freq_value   = m.frequency;
         r.freq_spread  = fspr;
         r.freq_percent = spread_percent(fspr, freq_hi);
         r.last         = 1'b1;
         due_results.push_back(r);
      end else begin
         frame = '{FRAME_HEAD, m.peak_sample[7:0], {6'b0, m.peak_sample[9:8]},
                   m.cycle_count[7:0], m.cycle_count[15:8], FRAME_TAIL};
         for (int k = 0; k < FRAME_LEN; k++) begin
            r = '0;
            r.kind       = KIND_FRAME;
            r.frame_byte = frame[k];
            r.last       = (k == FRAME_LEN - 1);
            due_results.push_back(r);
         end
      end
   endtask

   task automatic compare_field(input string fname, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("%0t ns result %0d: %s expected %0h got %0h",
                     $realtime, results_seen, fname, want, got);
      end
   endtask

   // compare one accepted result against the oldest prediction
   task automatic check_result(input lcmm_rsp_type got);
      lcmm_rsp_type want;
      results_seen++;
      if (due_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("%0t ns result %0d arrived with none predicted: %p",
                     $realtime, results_seen, got);
         return;
      end
      want = due_results.pop_front();
      if (want.kind == KIND_STATS)
         stats_count++;
      else
         byte_count++;
      compare_field("kind", want.kind, got.kind);
      compare_field("peak_value", want.peak_value, got.peak_value);
      compare_field("peak_spread", want.peak_spread, got.peak_spread);
      compare_field("peak_percent", want.peak_percent, got.peak_percent);
      compare_field("cycle_value", want.cycle_value, got.cycle_value);
      compare_field("freq_value", want.freq_value, got.freq_value);
      compare_field("freq_spread", want.freq_spread, got.freq_spread);
      compare_field("freq_percent", want.freq_percent, got.freq_percent);
      compare_field("frame_byte", want.frame_byte, got.frame_byte);
      compare_field("last", want.last, got.last);
   endtask

   // sample both handshakes at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         empty_marks();
         btn_last       = 1'b1;
         frame_mode     = 1'b0;
         due_results.delete();
         mismatch_count = 0;
         results_seen   = 0;
         item_count     = 0;
         stats_count    = 0;
         byte_count     = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result(rsp_item);
         if (req_valid && !req_stall) begin
            item_count++;
            fold_measurement(req_item);
         end
      end
      mismatches    <= mismatch_count;
      outstanding   <= due_results.size();
      items_taken   <= item_count;
      stats_checked <= stats_count;
      bytes_checked <= byte_count;
   end

endmodule

### bench/lc_sample_min_max_tracker_top_tb.sv
// lc_sample_min_max_tracker_top_tb: clock, reset, measurement stimulus and verdict
`timescale 1ns / 1ps

module lc_sample_min_max_tracker_top_tb;
   import lcmm_pkg::*;

   localparam int RANDOM_ITEMS = 310;
   localparam int DRAIN_LIMIT  = 4000;
   localparam int TAIL_CYCLES  = 40;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   lcmm_req_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   lcmm_rsp_type rsp_item;

   int           fail_count;
   int           outstanding;
   int           items_taken;
   int           stats_checked;
   int           bytes_checked;

   bit           calm = 1'b0;
   int unsigned  stall_hold = 0;

   lc_sample_min_max_tracker_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   lcmm_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item      (rsp_item),
      .mismatches    (fail_count),
      .outstanding   (outstanding),
      .items_taken   (items_taken),
      .stats_checked (stats_checked),
      .bytes_checked (bytes_checked)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // overall time limit
   initial begin
      #2000000;
      $display("run timed out");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // idle length: mostly none or short, now and then long
   function automatic int unsigned idle_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm)
         return 0;
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver back-pressure in runs of random length
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall  <= !calm && ($urandom_range(0, 99) < 40);
         stall_hold <= idle_len();
      end
   end

   function automatic lcmm_req_type measurement(input logic [23:0] f, input logic [9:0] p,
                                                input logic [15:0] c, input logic b);
      lcmm_req_type m;
      m.frequency    = f;
      m.peak_sample  = p;
      m.cycle_count  = c;
      m.button_level = b;
      return m;
   endfunction

   // random measurement with extremes mixed in
   function automatic lcmm_req_type random_measurement(input logic b);
      logic [23:0] f;
      logic [9:0]  p;
      logic [15:0] c;
      case ($urandom_range(0, 9))
         0: f = '0;
         1: f = '1;
         2: f = 24'($urandom_range(0, 255));
         default: f = 24'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: p = '0;
         1: p = '1;
         default: p = 10'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: c = '0;
         1: c = '1;
         default: c = 16'($urandom);
      endcase
      return measurement(f, p, c, b);
   endfunction

   // present one item after an optional gap and hold it until taken
   task automatic send_item(input lcmm_req_type m);
      int unsigned gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= m;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      int sent;
      int run_len;
      int press_len;
      int waited;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero maximum, full range, presses, frame bytes at the extremes
      send_item(measurement(24'h000000, 10'h000, 16'h0000, 1'b1));
      send_item(measurement(24'hFFFFFF, 10'h3FF, 16'hFFFF, 1'b1));
      send_item(measurement(24'h000001, 10'h001, 16'h0001, 1'b1));
      send_item(measurement(24'h800000, 10'h200, 16'h8000, 1'b1));
      send_item(measurement(24'hFFFFFF, 10'h3FF, 16'hFFFF, 1'b0));
      send_item(measurement(24'h000000, 10'h000, 16'h0000, 1'b0));
      send_item(measurement(24'h000000, 10'h3FF, 16'hFFFF, 1'b1));
      send_item(measurement(24'hFFFFFF, 10'h000, 16'h0000, 1'b1));
      send_item(measurement(24'h555555, 10'h155, 16'hAAAA, 1'b1));
      send_item(measurement(24'hAAAAAA, 10'h2AA, 16'h5555, 1'b1));
      send_item(measurement(24'h123456, 10'h0F0, 16'h1234, 1'b0));
      send_item(measurement(24'hFFFFFF, 10'h3FF, 16'hFFFF, 1'b1));
      send_item(measurement(24'h000000, 10'h000, 16'h0000, 1'b1));
      send_item(measurement(24'h123456, 10'h02F, 16'h1234, 1'b1));
      send_item(measurement(24'h000064, 10'h064, 16'h00FF, 1'b1));

      // random: runs of released measurements broken by presses of a few items
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         calm    = ($urandom_range(0, 4) == 0);
         run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
         for (int i = 0; i < run_len; i++) begin
            send_item(random_measurement(1'b1));
            sent++;
         end
         press_len = $urandom_range(1, 3);
         for (int i = 0; i < press_len; i++) begin
            send_item(random_measurement(1'b0));
            sent++;
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // drain the remaining results
      waited = 0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (outstanding != 0)
         $display("%0d predicted results never arrived", outstanding);
      $display("%0d measurements taken; checked %0d statistics results and %0d frame bytes",
               items_taken, stats_checked, bytes_checked);
      $display("mismatches counted: %0d", fail_count);
      if (fail_count == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### filelist.f
hdl/lcmm_pkg.sv
hdl/lcmm_pct_div.sv
hdl/lc_sample_min_max_tracker_top.sv
bench/lcmm_checker.sv
bench/lc_sample_min_max_tracker_top_tb.sv
